>>> rtl/sva_pkg.sv
// ----------------------------------------------------------------------------
// Voice allocator package
// Types, item structs, codes and reset constants shared by the allocator files.
// ----------------------------------------------------------------------------
`default_nettype none

package sva_pkg;

   localparam int          DEFAULT_MAX_VOICES = 8;
   localparam logic [3:0]  VOICE_COUNT_RESET  = 4'd4;
   localparam logic [31:0] AGE_NONE           = 32'hFFFF_FFFF;
   localparam logic [31:0] AGE_COUNTER_RESET  = 32'd1;

   localparam int          CSR_INDEX_W = 2;
   localparam int          CSR_DATA_W  = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_VOICE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEGATO_MODE = 2'd1;

   typedef enum logic [1:0] {
      CMD_NOTE_ON       = 2'd0,
      CMD_NOTE_OFF      = 2'd1,
      CMD_GRAINS_STATUS = 2'd2,
      CMD_ALL_OFF       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_COMMIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] note_number;
      logic [6:0] note_velocity;
      logic [2:0] status_voice;
      logic       grains_running;
   } req_item_type;

   typedef struct packed {
      logic [2:0] chosen_voice;
      logic       restart;
      logic       stolen;
      logic [7:0] released_mask;
      logic [3:0] busy_voices;
   } rsp_item_type;

   typedef struct packed {
      logic [6:0]  note;
      logic [6:0]  velocity;
      logic [31:0] age;
   } voice_entry_type;

endpackage

`default_nettype wire

>>> rtl/synth_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// Voice allocator core
// Polyphonic voice table with first-free, oldest-released, oldest-overall steal.
// ----------------------------------------------------------------------------
// Note, velocity and age of each voice sit in a synchronous RAM; the active,
// gate and grains-busy flags sit in flip-flops. Grains status, all-off, legato
// note-on and a note-on that finds a free voice go from EXEC to FINISH. Note-off
// and a stealing note-on walk SCAN over the n voices in use, and a stealing
// note-on then passes COMMIT; the RAM read port walks the table one voice a
// cycle. One item is in flight at a time; a new item is taken while the
// previous result waits in the output register.
`default_nettype none

module synth_voice_allocator_core
   import sva_pkg::*;
#(
   parameter int MAX_VOICES = DEFAULT_MAX_VOICES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_item_type           req_item,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_item_type                rsp_item,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int VIDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VOICES + 1);

   function automatic logic [CNT_W-1:0] used_count(input logic [3:0] cnt, input logic leg);
      logic [CNT_W-1:0] n;
      if (leg) begin
         n = CNT_W'(1);
      end else if (cnt == 4'd0) begin
         n = CNT_W'(1);
      end else if ({1'b0, cnt} > 5'(MAX_VOICES)) begin
         n = CNT_W'(MAX_VOICES);
      end else begin
         n = CNT_W'(cnt);
      end
      return n;
   endfunction

   state_type              state_ff, state_in;
   req_item_type           item_ff;
   logic [3:0]             voice_count_ff;
   logic                   legato_ff;
   logic [MAX_VOICES-1:0]  active_ff, gate_ff, grains_ff, written_ff;
   logic [31:0]            age_ctr_ff;
   logic [VIDX_W-1:0]      idx_ff;
   logic                   rel_found_ff;
   logic [31:0]            rel_age_ff, all_age_ff;
   logic [VIDX_W-1:0]      rel_idx_ff, all_idx_ff;
   logic [MAX_VOICES-1:0]  rmask_ff;
   logic [VIDX_W-1:0]      chosen_ff;
   logic                   restart_ff, stolen_ff;
   logic                   rsp_valid_ff;
   rsp_item_type           rsp_item_ff;

   logic [CNT_W-1:0]       n_cur, n_new, n_last;
   logic [3:0]             cfg_count;
   logic                   cfg_legato, cfg_shrink;
   logic [MAX_VOICES-1:0]  in_range, keep_mask;
   logic                   free_found;
   logic [VIDX_W-1:0]      free_idx;
   logic                   fast_on, needs_scan, scan_last;
   logic                   do_commit, do_scan, do_start, do_grains, do_alloff, do_load, do_accept;
   logic [VIDX_W-1:0]      rd_addr, commit_v, sv_idx;
   logic                   sv_ok;
   voice_entry_type        rd_entry, wr_entry;
   logic [31:0]            scan_age;
   logic [6:0]             scan_note;
   logic                   rel_cand, all_cand, off_match;
   logic [CNT_W-1:0]       busy_cnt;
   logic [MAX_VOICES+7:0]  rmask_ext;
   logic [VIDX_W+2:0]      chosen_ext;
   logic [CNT_W+3:0]       busy_ext;

   // ------------------------------------------------------------------
   assign n_cur      = used_count(voice_count_ff, legato_ff);
   assign n_last     = n_cur - CNT_W'(1);
   assign cfg_count  = (csr_index == CSR_VOICE_COUNT) ? csr_wdata : voice_count_ff;
   assign cfg_legato = (csr_index == CSR_LEGATO_MODE) ? csr_wdata[0] : legato_ff;
   assign n_new      = used_count(cfg_count, cfg_legato);
   assign cfg_shrink = csr_we && (n_new < n_cur);

   always_comb begin
      for (int i = 0; i < MAX_VOICES; i++) begin
         in_range[i]  = CNT_W'(i) < n_cur;
         keep_mask[i] = CNT_W'(i) < n_new;
      end
   end

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_VOICES - 1; i >= 0; i--) begin
         if (in_range[i] && !active_ff[i] && !grains_ff[i]) begin
            free_found = 1'b1;
            free_idx   = VIDX_W'(i);
         end
      end
   end

   assign fast_on    = legato_ff || free_found;
   assign needs_scan = (item_ff.cmd == CMD_NOTE_OFF) ||
                       ((item_ff.cmd == CMD_NOTE_ON) && !fast_on);
   assign scan_last  = (CNT_W'(idx_ff) == n_last);

   assign scan_age  = written_ff[idx_ff] ? rd_entry.age  : '0;
   assign scan_note = written_ff[idx_ff] ? rd_entry.note : '0;
   assign rel_cand  = active_ff[idx_ff] && !gate_ff[idx_ff] && (scan_age < rel_age_ff);
   assign all_cand  = scan_age < all_age_ff;
   assign off_match = (item_ff.cmd == CMD_NOTE_OFF) && active_ff[idx_ff] &&
                      gate_ff[idx_ff] && (scan_note == item_ff.note_number);

   assign sv_idx = VIDX_W'(item_ff.status_voice);
   assign sv_ok  = {{CNT_W{1'b0}}, item_ff.status_voice} < {3'b000, n_cur};

   always_comb begin
      if (state_ff == ST_EXEC) begin
         commit_v = legato_ff ? '0 : free_idx;
      end else begin
         commit_v = rel_found_ff ? rel_idx_ff : all_idx_ff;
      end
   end

   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = needs_scan ? ST_SCAN : ST_FINISH;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = (item_ff.cmd == CMD_NOTE_ON) ? ST_COMMIT : ST_FINISH;
            end
         end
         ST_COMMIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      do_accept = 1'b0;
      do_commit = 1'b0;
      do_start  = 1'b0;
      do_scan   = 1'b0;
      do_grains = 1'b0;
      do_alloff = 1'b0;
      do_load   = 1'b0;
      rd_addr   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            do_accept = req_valid;
         end
         ST_EXEC: begin
            rd_addr   = '0;
            do_start  = 1'b1;
            do_commit = (item_ff.cmd == CMD_NOTE_ON) && fast_on;
            do_grains = (item_ff.cmd == CMD_GRAINS_STATUS);
            do_alloff = (item_ff.cmd == CMD_ALL_OFF);
         end
         ST_SCAN: begin
            rd_addr = VIDX_W'(idx_ff + 1'b1);
            do_scan = 1'b1;
         end
         ST_COMMIT: begin
            do_commit = 1'b1;
         end
         ST_FINISH: begin
            do_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            rd_addr = idx_ff;
         end
      endcase
   end

   // ------------------------------------------------------------------
   assign wr_entry = '{note: item_ff.note_number, velocity: item_ff.note_velocity,
                       age: age_ctr_ff};

   sva_ram #(
      .WIDTH($bits(voice_entry_type)),
      .DEPTH(MAX_VOICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (do_commit),
      .wr_addr (commit_v),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         voice_count_ff <= VOICE_COUNT_RESET;
         legato_ff      <= 1'b0;
         active_ff      <= '0;
         gate_ff        <= '0;
         grains_ff      <= '0;
         written_ff     <= '0;
         age_ctr_ff     <= AGE_COUNTER_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            voice_count_ff <= cfg_count;
            legato_ff      <= cfg_legato;
         end
         if (do_commit) begin
            active_ff[commit_v]  <= 1'b1;
            gate_ff[commit_v]    <= 1'b1;
            written_ff[commit_v] <= 1'b1;
            age_ctr_ff           <= age_ctr_ff + 32'd1;
         end
         if (do_scan && off_match) begin
            gate_ff[idx_ff] <= 1'b0;
         end
         if (do_grains && sv_ok) begin
            grains_ff[sv_idx] <= item_ff.grains_running;
            if (!gate_ff[sv_idx] && !item_ff.grains_running) begin
               active_ff[sv_idx] <= 1'b0;
            end
         end
         if (do_alloff) begin
            active_ff <= '0;
            gate_ff   <= '0;
            grains_ff <= '0;
         end
         if (cfg_shrink) begin
            active_ff <= active_ff & keep_mask;
            gate_ff   <= gate_ff & keep_mask;
            grains_ff <= grains_ff & keep_mask;
         end
         if (do_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_accept) begin
         item_ff <= req_item;
      end
      if (do_start) begin
         idx_ff       <= '0;
         rel_found_ff <= 1'b0;
         rel_age_ff   <= AGE_NONE;
         all_age_ff   <= AGE_NONE;
         all_idx_ff   <= '0;
         rmask_ff     <= do_alloff ? gate_ff : '0;
      end
      if (do_scan) begin
         idx_ff <= VIDX_W'(idx_ff + 1'b1);
         if (rel_cand) begin
            rel_found_ff <= 1'b1;
            rel_age_ff   <= scan_age;
            rel_idx_ff   <= idx_ff;
         end
         if (all_cand) begin
            all_age_ff <= scan_age;
            all_idx_ff <= idx_ff;
         end
         if (off_match) begin
            rmask_ff[idx_ff] <= 1'b1;
         end
      end
      if (do_commit) begin
         chosen_ff  <= commit_v;
         stolen_ff  <= active_ff[commit_v] || grains_ff[commit_v];
         restart_ff <= !(legato_ff && active_ff[commit_v] && gate_ff[commit_v]);
      end else if (do_start) begin
         chosen_ff  <= '0;
         restart_ff <= 1'b0;
         stolen_ff  <= 1'b0;
      end
      if (do_load) begin
         rsp_item_ff <= '{chosen_voice: chosen_ext[2:0], restart: restart_ff,
                          stolen: stolen_ff, released_mask: rmask_ext[7:0],
                          busy_voices: busy_ext[3:0]};
      end
   end

   // ------------------------------------------------------------------
   always_comb begin
      busy_cnt = '0;
      for (int i = 0; i < MAX_VOICES; i++) begin
         if (in_range[i] && (active_ff[i] || grains_ff[i])) begin
            busy_cnt = busy_cnt + CNT_W'(1);
         end
      end
   end

   assign rmask_ext  = {8'd0, rmask_ff};
   assign chosen_ext = {3'd0, chosen_ff};
   assign busy_ext   = {4'd0, busy_cnt};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

>>> rtl/sva_ram.sv
// ----------------------------------------------------------------------------
// Voice allocator RAM
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/sva_checker.sv
// ----------------------------------------------------------------------------
// Voice allocator checker
// Port-level properties of the allocator core, bound into that module.
// ----------------------------------------------------------------------------
`default_nettype none

module sva_checker
   import sva_pkg::*;
#(
   parameter int MAX_VOICES = DEFAULT_MAX_VOICES
) (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in flight");

   a_release_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.released_mask != 8'd0) |->
         !rsp_item.restart && !rsp_item.stolen && (rsp_item.chosen_voice == 3'd0))
      else $error("release item carries note-on fields");

   a_busy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({28'd0, rsp_item.busy_voices} <= 32'(MAX_VOICES)))
      else $error("busy voice count above table size");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind synth_voice_allocator_core sva_checker #(.MAX_VOICES(MAX_VOICES)) u_sva_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Voice allocator core testbench
// Drives note on, note off, grains status and all-off items into the core
// over the req_ channel and keeps its own model of the voice table. The
// model predicts every result, and a checker on the rsp_ channel compares
// each one field by field. Directed cases come first, then a back-pressure
// run, then random phases over several voice counts and legato settings,
// with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench
   import sva_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VOICES        = DEFAULT_MAX_VOICES;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int RANDOM_PHASES = 12;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REQ_BITS      = $bits(req_item_type);

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_item_type           req_item  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_item_type           rsp_item;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off       = 0;

   rsp_item_type pending_rsp[$];

   // voice table model
   logic        voice_on     [VOICES];
   logic        voice_held   [VOICES];
   logic        voice_grains [VOICES];
   logic [6:0]  voice_pitch  [VOICES];
   logic [6:0]  voice_vel    [VOICES];
   logic [31:0] voice_stamp  [VOICES];
   logic [31:0] stamp_next;
   logic [3:0]  count_reg;
   logic        legato_reg;

   synth_voice_allocator_core #(
      .MAX_VOICES(VOICES)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   function automatic void reset_model();
      for (int i = 0; i < VOICES; i++) begin
         voice_on[i]     = 1'b0;
         voice_held[i]   = 1'b0;
         voice_grains[i] = 1'b0;
         voice_pitch[i]  = '0;
         voice_vel[i]    = '0;
         voice_stamp[i]  = '0;
      end
      stamp_next = AGE_COUNTER_RESET;
      count_reg  = VOICE_COUNT_RESET;
      legato_reg = 1'b0;
   endfunction

   function automatic int voices_in_use();
      if (legato_reg)
         return 1;
      if (count_reg < 1)
         return 1;
      if (count_reg > VOICES)
         return VOICES;
      return int'(count_reg);
   endfunction

   function automatic void clear_voice(int v);
      voice_on[v]     = 1'b0;
      voice_held[v]   = 1'b0;
      voice_grains[v] = 1'b0;
   endfunction

   function automatic void write_register(logic [CSR_INDEX_W-1:0] idx,
                                          logic [CSR_DATA_W-1:0] data);
      int old_n;
      int new_n;
      old_n = voices_in_use();
      case (idx)
         CSR_VOICE_COUNT: count_reg = data;
         CSR_LEGATO_MODE: legato_reg = data[0];
         default: return;
      endcase
      new_n = voices_in_use();
      if (new_n < old_n)
         for (int i = new_n; i < VOICES; i++)
            clear_voice(i);
   endfunction

   function automatic int choose_voice(int n);
      int          best;
      logic [31:0] best_stamp;
      for (int i = 0; i < n; i++)
         if (!voice_on[i] && !voice_grains[i])
            return i;
      best       = -1;
      best_stamp = AGE_NONE;
      for (int i = 0; i < n; i++) begin
         if (voice_on[i] && !voice_held[i] && voice_stamp[i] < best_stamp) begin
            best_stamp = voice_stamp[i];
            best       = i;
         end
      end
      if (best >= 0)
         return best;
      best       = 0;
      best_stamp = AGE_NONE;
      for (int i = 0; i < n; i++) begin
         if (voice_stamp[i] < best_stamp) begin
            best_stamp = voice_stamp[i];
            best       = i;
         end
      end
      return best;
   endfunction

   function automatic rsp_item_type apply_event(req_item_type it);
      rsp_item_type r;
      int           n;
      int           v;
      int           sv;
      int           busy;
      r    = '0;
      n    = voices_in_use();
      busy = 0;
      case (it.cmd)
         CMD_NOTE_ON: begin
            v              = legato_reg ? 0 : choose_voice(n);
            r.stolen       = voice_on[v] | voice_grains[v];
            r.restart      = !(legato_reg && voice_on[v] && voice_held[v]);
            voice_on[v]    = 1'b1;
            voice_held[v]  = 1'b1;
            voice_pitch[v] = it.note_number;
            voice_vel[v]   = it.note_velocity;
            voice_stamp[v] = stamp_next;
            stamp_next     = stamp_next + 32'd1;
            r.chosen_voice = 3'(v);
         end
         CMD_NOTE_OFF: begin
            for (int i = 0; i < n; i++) begin
               if (voice_on[i] && voice_held[i] && voice_pitch[i] == it.note_number) begin
                  voice_held[i]      = 1'b0;
                  r.released_mask[i] = 1'b1;
               end
            end
         end
         CMD_GRAINS_STATUS: begin
            sv = int'(it.status_voice);
            if (sv < n) begin
               voice_grains[sv] = it.grains_running;
               if (!voice_held[sv] && !it.grains_running)
                  voice_on[sv] = 1'b0;
            end
         end
         default: begin
            for (int i = 0; i < VOICES; i++) begin
               if (voice_held[i])
                  r.released_mask[i] = 1'b1;
               clear_voice(i);
            end
         end
      endcase
      for (int i = 0; i < n; i++)
         if (voice_on[i] || voice_grains[i])
            busy++;
      r.busy_voices = 4'(busy);
      return r;
   endfunction

   // receiver side: long hold-off first, then random stalls
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result with no item outstanding: %h", rsp_item);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("chosen_voice", 32'(want.chosen_voice),
                        32'(rsp_item.chosen_voice));
            check_field("restart", 32'(want.restart), 32'(rsp_item.restart));
            check_field("stolen", 32'(want.stolen), 32'(rsp_item.stolen));
            check_field("released_mask", 32'(want.released_mask),
                        32'(rsp_item.released_mask));
            check_field("busy_voices", 32'(want.busy_voices),
                        32'(rsp_item.busy_voices));
         end
      end
   end

   task automatic set_idle(int send_pct, int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic send_event(req_item_type it);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct)
         gap++;
      @(negedge clock);
      while (gap > 0) begin
         req_valid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do
         @(posedge clock);
      while (!req_ready);
      pending_rsp.push_back(apply_event(it));
   endtask

   task automatic drain_events();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain_events();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      write_register(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_item_type make_event(cmd_type c, int note, int vel, int sv,
                                               int run);
      req_item_type it;
      it.cmd            = c;
      it.note_number    = 7'(note);
      it.note_velocity  = 7'(vel);
      it.status_voice   = 3'(sv);
      it.grains_running = 1'(run);
      return it;
   endfunction

   task automatic send_random_event();
      logic [REQ_BITS-1:0] raw;
      req_item_type        it;
      int                  r;
      int                  n;
      int                  cand[$];
      raw = REQ_BITS'($urandom);
      it  = raw;
      r   = $urandom_range(99);
      n   = voices_in_use();
      if (r < 42) begin
         it.cmd = CMD_NOTE_ON;
         if ($urandom_range(3) != 0)
            it.note_number = 7'($urandom_range(67, 60));
      end else if (r < 70) begin
         it.cmd = CMD_NOTE_OFF;
         for (int i = 0; i < n; i++)
            if (voice_on[i] && voice_held[i])
               cand.push_back(i);
         if (cand.size() > 0)
            it.note_number = voice_pitch[cand[$urandom_range(cand.size() - 1)]];
         else
            it.note_number = 7'($urandom_range(67, 60));
      end else if (r < 92) begin
         it.cmd = CMD_GRAINS_STATUS;
         for (int i = 0; i < n; i++)
            if (voice_on[i] && !voice_held[i])
               cand.push_back(i);
         if (cand.size() > 0 && $urandom_range(4) != 0) begin
            it.status_voice   = 3'(cand[$urandom_range(cand.size() - 1)]);
            it.grains_running = ($urandom_range(3) == 0);
         end
      end else if (r < 95) begin
         it.cmd = CMD_ALL_OFF;
      end
      send_event(it);
   endtask

   task automatic test_free_and_steal();
      set_idle(0, 0);
      send_event(make_event(CMD_NOTE_ON, 127, 127, 0, 0));
      send_event(make_event(CMD_NOTE_ON, 0, 0, 7, 1));
      send_event(make_event(CMD_NOTE_ON, 64, 33, 0, 0));
      send_event(make_event(CMD_NOTE_ON, 65, 90, 0, 0));
      // all gated: take the oldest of all
      send_event(make_event(CMD_NOTE_ON, 10, 1, 0, 0));
      send_event(make_event(CMD_NOTE_OFF, 0, 0, 0, 0));
      // oldest released wins over oldest gated
      send_event(make_event(CMD_NOTE_ON, 11, 2, 0, 0));
      drain_events();
   endtask

   task automatic test_release_and_grains();
      send_event(make_event(CMD_NOTE_OFF, 64, 0, 0, 0));
      send_event(make_event(CMD_GRAINS_STATUS, 0, 0, 2, 1));
      send_event(make_event(CMD_GRAINS_STATUS, 0, 0, 2, 0));
      // gated voice: only the busy flag changes
      send_event(make_event(CMD_GRAINS_STATUS, 0, 0, 3, 0));
      // voice beyond the count: ignored
      send_event(make_event(CMD_GRAINS_STATUS, 0, 0, 7, 1));
      drain_events();
   endtask

   task automatic test_all_off();
      send_event(make_event(CMD_ALL_OFF, 0, 0, 0, 0));
      send_event(make_event(CMD_GRAINS_STATUS, 0, 0, 5, 1));
      send_event(make_event(CMD_NOTE_ON, 100, 50, 0, 0));
      drain_events();
   endtask

   task automatic test_legato();
      write_csr(CSR_LEGATO_MODE, 4'd1);
      send_event(make_event(CMD_NOTE_ON, 60, 70, 0, 0));
      send_event(make_event(CMD_NOTE_ON, 62, 71, 0, 0));
      send_event(make_event(CMD_NOTE_OFF, 62, 0, 0, 0));
      send_event(make_event(CMD_NOTE_ON, 63, 72, 0, 0));
      drain_events();
   endtask

   task automatic test_count_limits();
      write_csr(CSR_LEGATO_MODE, 4'd0);
      write_csr(CSR_VOICE_COUNT, 4'd0);
      send_event(make_event(CMD_NOTE_ON, 20, 20, 0, 0));
      write_csr(CSR_VOICE_COUNT, 4'd15);
      send_event(make_event(CMD_GRAINS_STATUS, 0, 0, 7, 1));
      send_event(make_event(CMD_NOTE_ON, 21, 21, 0, 0));
      write_csr(CSR_VOICE_COUNT, 4'd8);
      // indexes past the register list
      write_csr(2'd2, 4'd15);
      write_csr(2'd3, 4'd15);
      write_csr(CSR_VOICE_COUNT, 4'd2);
      send_event(make_event(CMD_NOTE_OFF, 21, 0, 0, 0));
      drain_events();
   endtask

   task automatic test_backpressure();
      set_idle(0, 0);
      hold_off = 300;
      repeat (12) send_random_event();
      drain_events();
   endtask

   task automatic test_random_traffic();
      logic [3:0] count_val;
      logic       legato_val;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: begin count_val = 4'd8; legato_val = 1'b0; end
            1: begin count_val = 4'd1; legato_val = 1'b0; end
            2: begin count_val = 4'd0; legato_val = 1'b0; end
            3: begin count_val = 4'd15; legato_val = 1'b0; end
            4: begin count_val = 4'd5; legato_val = 1'b1; end
            5: begin count_val = 4'd8; legato_val = 1'b0; end
            6: begin count_val = 4'd2; legato_val = 1'b0; end
            7: begin count_val = 4'd8; legato_val = 1'b1; end
            default: begin
               count_val  = 4'($urandom_range(15));
               legato_val = ($urandom_range(3) == 0);
            end
         endcase
         write_csr(CSR_VOICE_COUNT, count_val);
         write_csr(CSR_LEGATO_MODE, {3'($urandom_range(7)), legato_val});
         case (ph % 4)
            0: set_idle(0, 0);
            1: set_idle(56, 0);
            2: set_idle(0, 56);
            default: set_idle(6, 6);
         endcase
         for (int k = 0; k < RANDOM_ITEMS / RANDOM_PHASES; k++) begin
            send_random_event();
            if ($urandom_range(49) == 0)
               drain_events();
         end
      end
   endtask

   initial begin
      reset_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_free_and_steal();
      test_release_and_grains();
      test_all_off();
      test_legato();
      test_count_limits();
      test_backpressure();
      test_random_traffic();
      drain_events();
      repeat (20) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d results never arrived", pending_rsp.size());
         error_count++;
      end
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
